[rtl/core/rfd_pkg.sv]
// shared types, constants and the crc byte update for the request frame deframer
package rfd_pkg;

  localparam int unsigned HDR_LEN   = 24;
  localparam int unsigned MAX_W     = 21;
  localparam logic [4:0]  HDR_LAST  = 5'(HDR_LEN - 1);
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
  localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(1024 * 1024);
  localparam logic [7:0]  VERSION_LO = 8'h01;
  localparam logic [7:0]  VERSION_HI = 8'h00;

  // expected magic bytes in stream order
  localparam logic [7:0] MAGIC [4] = '{8'h47, 8'h4D, 8'h52, 8'h51};

  // verdict codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_HDR   = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_CRC_BAD   = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_HALT    = 3'b100
  } phase_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        frame_done;
    logic [1:0]  status;
    logic [15:0] operation;
    logic [31:0] sequence_res;
    logic [31:0] payload_length;
    logic [31:0] reset_count;
  } result_t;

  // reflected crc-32, eight bit rounds for one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[rtl/core/rfd_in_stage.sv]
// input register stage holding one accepted word
module rfd_in_stage import rfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic load;

  // room when empty or when the held word moves on this cycle
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_byte <= data_byte;
    end
  end

endmodule

[rtl/core/rfd_parser.sv]
// header parser, length check and payload crc state machine
module rfd_parser import rfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       b,
  input  logic [MAX_W-1:0] max_payload_bytes,
  output result_t          res
);

  phase_t            phase, phase_next;
  logic [4:0]        header_index, header_index_next;
  logic              header_ok, header_ok_next;
  logic [15:0]       op_code_reg, op_code_reg_next;
  logic [31:0]       sequence_reg, sequence_reg_next;
  logic [31:0]       length_reg, length_reg_next;
  logic [31:0]       iterations_reg, iterations_reg_next;
  logic [31:0]       expected_crc_reg, expected_crc_reg_next;
  logic [31:0]       running_crc, running_crc_next;
  logic [MAX_W-1:0]  bytes_left, bytes_left_next;
  logic              byte_ok;
  logic              hdr_ok_now;
  logic [31:0]       crc_upd;

  always_comb begin
    phase_next            = phase;
    header_index_next     = header_index;
    header_ok_next        = header_ok;
    op_code_reg_next      = op_code_reg;
    sequence_reg_next     = sequence_reg;
    length_reg_next       = length_reg;
    iterations_reg_next   = iterations_reg;
    expected_crc_reg_next = expected_crc_reg;
    running_crc_next      = running_crc;
    bytes_left_next       = bytes_left;
    byte_ok               = 1'b1;
    hdr_ok_now            = header_ok;
    crc_upd               = crc_byte(running_crc, b);
    res                   = '0;

    unique case (phase)
      PH_HEADER: begin
        case (header_index) inside
          [5'd0:5'd3]:   byte_ok = (b == MAGIC[header_index[1:0]]);
          5'd4:          byte_ok = (b == VERSION_LO);
          5'd5:          byte_ok = (b == VERSION_HI);
          [5'd6:5'd7]:   op_code_reg_next[8*header_index[0] +: 8] = b;
          [5'd8:5'd11]:  sequence_reg_next[8*header_index[1:0] +: 8] = b;
          [5'd12:5'd15]: length_reg_next[8*header_index[1:0] +: 8] = b;
          [5'd16:5'd19]: iterations_reg_next[8*header_index[1:0] +: 8] = b;
          default:       expected_crc_reg_next[8*header_index[1:0] +: 8] = b;
        endcase
        hdr_ok_now     = header_ok && byte_ok;
        header_ok_next = hdr_ok_now;
        if (header_index != HDR_LAST) begin
          header_index_next = header_index + 5'd1;
        end else begin
          header_index_next = 5'd0;
          if (!hdr_ok_now) begin
            res.valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = ST_BAD_HDR;
            phase_next     = PH_HALT;
          end else if (length_reg_next > {{(32-MAX_W){1'b0}}, max_payload_bytes}) begin
            res.valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = ST_TOO_LARGE;
            phase_next     = PH_HALT;
          end else if (length_reg_next == 32'd0) begin
            res.valid      = 1'b1;
            res.frame_done = 1'b1;
            if (expected_crc_reg_next == 32'd0) begin
              res.status       = ST_OK;
              header_ok_next   = 1'b1;
              running_crc_next = CRC_ONES;
              bytes_left_next  = '0;
            end else begin
              res.status = ST_CRC_BAD;
              phase_next = PH_HALT;
            end
          end else begin
            bytes_left_next  = length_reg_next[MAX_W-1:0];
            running_crc_next = CRC_ONES;
            phase_next       = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        running_crc_next = crc_upd;
        bytes_left_next  = bytes_left - MAX_W'(1);
        res.valid        = 1'b1;
        res.byte_valid   = 1'b1;
        res.payload_byte = b;
        if (bytes_left_next == '0) begin
          res.frame_done = 1'b1;
          if ((crc_upd ^ CRC_ONES) == expected_crc_reg) begin
            res.status        = ST_OK;
            header_index_next = 5'd0;
            header_ok_next    = 1'b1;
            running_crc_next  = CRC_ONES;
            phase_next        = PH_HEADER;
          end else begin
            res.status = ST_CRC_BAD;
            phase_next = PH_HALT;
          end
        end
      end
      default: begin
        // halted: bytes are dropped
      end
    endcase

    res.operation      = op_code_reg_next;
    res.sequence_res   = sequence_reg_next;
    res.payload_length = length_reg_next;
    res.reset_count    = iterations_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_index     <= 5'd0;
      header_ok        <= 1'b1;
      op_code_reg      <= '0;
      sequence_reg     <= '0;
      length_reg       <= '0;
      iterations_reg   <= '0;
      expected_crc_reg <= '0;
      running_crc      <= CRC_ONES;
      bytes_left       <= '0;
    end else if (step) begin
      phase            <= phase_next;
      header_index     <= header_index_next;
      header_ok        <= header_ok_next;
      op_code_reg      <= op_code_reg_next;
      sequence_reg     <= sequence_reg_next;
      length_reg       <= length_reg_next;
      iterations_reg   <= iterations_reg_next;
      expected_crc_reg <= expected_crc_reg_next;
      running_crc      <= running_crc_next;
      bytes_left       <= bytes_left_next;
    end
  end

`ifndef SYNTHESIS
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_left != '0)
    else $error("payload phase with no bytes left");
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_HALT |-> !res.valid)
    else $error("result produced while halted");
  a_hdr_index: assert property (@(posedge clk) disable iff (rst)
    header_index <= HDR_LAST)
    else $error("header index past header end");
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && !res.byte_valid |-> res.frame_done)
    else $error("result without payload or verdict");
`endif

endmodule

[rtl/core/request_frame_deframer_crc32.sv]
// top level of the request frame deframer with crc-32 check
// Takes one byte word per cycle while in_stall is low: a 24-byte little-endian
// header (magic, version 1, operation, sequence, payload length, reset
// iterations, expected crc), then the payload, which is passed through while a
// reflected crc-32 runs over it. The verdict (ok, bad magic/version, too large,
// crc mismatch) rides on the last payload word, or on the last header word when
// the header is bad, the length is too large or the length is zero; header
// words other than the last give no result. Any error halts the block until
// reset, and later words are taken and dropped. Throughput is one word per
// cycle while out_stall is low. A word is registered in the input register,
// passes through the combinational parser and is registered in the result
// register. A stalled result holds the input register, so the block holds at
// most two words before it stalls its input. The user must see that
// max_payload_bytes is written through the cfg port only while idle; the block itself does not enforce this.
module request_frame_deframer_crc32 import rfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // input words
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  // result words
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       payload_byte,
  output logic             byte_valid,
  output logic             frame_done,
  output logic [1:0]       status,
  output logic [15:0]      operation,
  output logic [31:0]      sequence_res,
  output logic [31:0]      payload_length,
  output logic [31:0]      reset_count,
  // max payload register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MAX_W-1:0] cfg_data
);

  logic             advance;
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             step;
  logic [MAX_W-1:0] max_payload_bytes;
  result_t          res;
  result_t          out_q;

  // the held word moves when the result register is empty or being taken
  assign advance   = !out_valid || !out_stall;
  assign step      = s1_valid && advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_bytes <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_bytes <= cfg_data;
    end
  end

  rfd_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte)
  );

  rfd_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .b                 (s1_byte),
    .max_payload_bytes (max_payload_bytes),
    .res               (res)
  );

  // result register; header words that give no result leave it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign payload_byte   = out_q.payload_byte;
  assign byte_valid     = out_q.byte_valid;
  assign frame_done     = out_q.frame_done;
  assign status         = out_q.status;
  assign operation      = out_q.operation;
  assign sequence_res   = out_q.sequence_res;
  assign payload_length = out_q.payload_length;
  assign reset_count    = out_q.reset_count;

endmodule
